/* sv/bmhq_pkg.sv */
// Shared types and constants of the binary min-heap queue.
`timescale 1ns / 1ps
`default_nettype none
package bmhq_pkg;

  localparam int HEAP_DEPTH_DEF = 64;
  localparam int TAG_W          = 16;
  localparam int KEY_W          = 32;
  localparam int CNT_W          = 7;          // fill count and capacity register
  localparam int IDX_W          = CNT_W + 1;  // room for child indices 2i+2

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic {
    ACT_INSERT  = 1'b0,
    ACT_EXTRACT = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    STS_INSERTED = 2'd0,
    STS_OVERFLOW = 2'd1,
    STS_EXTRACT  = 2'd2,
    STS_EMPTY    = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_EX_RD,
    ST_EX_LOAD,
    ST_DN_RD,
    ST_DN_L,
    ST_DN_R,
    ST_DONE
  } state_e;

endpackage
`default_nettype wire

/* sv/bmhq_ram.sv */
// Generic RAM: one write port, two registered read ports with read enable.
`timescale 1ns / 1ps
`default_nettype none
module bmhq_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule
`default_nettype wire

/* sv/bmhq_key_cmp.sv */
// Shared signed key comparator of the heap sequencer.
`timescale 1ns / 1ps
`default_nettype none
module bmhq_key_cmp
  import bmhq_pkg::*;
(
  input  wire logic signed [KEY_W-1:0] a_key_i,
  input  wire logic signed [KEY_W-1:0] b_key_i,
  output logic                         a_lt_b_o
);

  // strict less-than: equal keys never move an entry
  assign a_lt_b_o = (a_key_i < b_key_i);

endmodule
`default_nettype wire

/* sv/binary_min_heap_queue_core.sv */
// Top level of the binary min-heap priority queue with its sift sequencer.
//
//  channel  | dir | handshake               | payload
//  ---------+-----+-------------------------+-----------------------------------------
//  s_axis   | in  | s_axis_tvalid/_tready   | tdata: item_tag, item_key; tuser: action
//  m_axis   | out | m_axis_tvalid/_tready   | tdata: out_tag, out_key, fill_count;
//           |     |                         | tuser: status
//  cfg      | in  | cfg_valid_i/cfg_ready_o | capacity_limit
//
// An insert climbs level by level from the new end toward the root; an extract moves the
// last entry to the root and sifts it down level by level; overflow and empty go straight
// to the result. All compares share the single comparator, and RAM reads are registered.
// Reset clears fill count, capacity (to the heap depth, at most 127) and control; RAM stays undefined.
// Take the next item while a result waits; stall at the end only while it is still held.
`timescale 1ns / 1ps
`default_nettype none
module binary_min_heap_queue_core
  import bmhq_pkg::*;
#(
  parameter int HEAP_DEPTH = HEAP_DEPTH_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // slave stream
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [47:0]      s_axis_tdata,   // [15:0] item_tag, [47:16] item_key
  input  wire logic [0:0]       s_axis_tuser,   // [0] action
  // master stream
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic      [55:0]      m_axis_tdata,   // [15:0] out_tag, [47:16] out_key,
                                                // [54:48] fill_count, [55] zero
  output logic      [1:0]       m_axis_tuser,   // [1:0] status
  // configuration write
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [CNT_W-1:0] cfg_data_i      // capacity_limit
);

  localparam int ADDR_W  = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  // largest fill the 7-bit count and the memory allow together
  localparam int CAP_MAX = (HEAP_DEPTH > (2**CNT_W - 1)) ? (2**CNT_W - 1) : HEAP_DEPTH;

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  state_e             state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   cap_q;
  logic [IDX_W-1:0]   idx_q, idx_d;      // current hole position
  entry_t             ent_q, ent_d;      // entry being sifted
  entry_t             best_q, best_d;    // left child when it beats the moving entry, else the moving entry
  logic               left_sel_q, left_sel_d;
  logic [TAG_W-1:0]   res_tag_q, res_tag_d;
  logic [KEY_W-1:0]   res_key_q, res_key_d;
  status_e            res_sts_q, res_sts_d;
  logic               m_valid_q, m_valid_d;
  logic [55:0]        m_data_q, m_data_d;
  status_e            m_user_q, m_user_d;

  // ---------------------------------------------------------------------------
  // heap RAM and shared comparator
  // ---------------------------------------------------------------------------
  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr_a, ram_raddr_b;
  entry_t             ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata_a, ram_rdata_b;
  entry_t             rd_a, rd_b;

  bmhq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (HEAP_DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .re_i      (ram_re),
    .raddr_a_i (ram_raddr_a),
    .raddr_b_i (ram_raddr_b),
    .rdata_a_o (ram_rdata_a),
    .rdata_b_o (ram_rdata_b)
  );

  assign rd_a = entry_t'(ram_rdata_a);
  assign rd_b = entry_t'(ram_rdata_b);

  logic signed [KEY_W-1:0] cmp_a, cmp_b;
  logic                    cmp_lt;

  bmhq_key_cmp u_cmp (
    .a_key_i  (cmp_a),
    .b_key_i  (cmp_b),
    .a_lt_b_o (cmp_lt)
  );

  // ---------------------------------------------------------------------------
  // index arithmetic
  // ---------------------------------------------------------------------------
  logic [IDX_W-1:0] parent_idx, left_idx, right_idx, count_ext;
  logic [CNT_W-1:0] eff_cap;
  logic             s_hs, full, right_ok;
  entry_t           in_ent;

  assign parent_idx = (idx_q - IDX_W'(1)) >> 1;
  assign left_idx   = {idx_q[IDX_W-2:0], 1'b1};
  assign right_idx  = left_idx + IDX_W'(1);
  assign count_ext  = IDX_W'(count_q);
  assign right_ok   = (right_idx < count_ext);

  // saturate the capacity register at what the store holds
  assign eff_cap = (cap_q > CNT_W'(CAP_MAX)) ? CNT_W'(CAP_MAX) : cap_q;
  assign full    = (count_q >= eff_cap);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_hs          = s_axis_tvalid && s_axis_tready;
  assign in_ent.tag    = s_axis_tdata[TAG_W-1:0];
  assign in_ent.key    = s_axis_tdata[TAG_W +: KEY_W];

  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // ---------------------------------------------------------------------------
  // sequencer: next state and datapath control
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    ent_d       = ent_q;
    best_d      = best_q;
    left_sel_d  = left_sel_q;
    res_tag_d   = res_tag_q;
    res_key_d   = res_key_q;
    res_sts_d   = res_sts_q;
    m_valid_d   = m_valid_q;
    m_data_d    = m_data_q;
    m_user_d    = m_user_q;
    ram_we      = 1'b0;
    ram_waddr   = ADDR_W'(idx_q);
    ram_wdata   = ent_q;
    ram_re      = 1'b0;
    ram_raddr_a = ADDR_W'(parent_idx);
    ram_raddr_b = ADDR_W'(right_idx);
    cmp_a       = rd_a.key;
    cmp_b       = ent_q.key;

    // drop the result once the sink takes it
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (s_hs) begin
          res_tag_d = '0;
          res_key_d = '0;
          if (action_e'(s_axis_tuser[0]) == ACT_INSERT) begin
            if (full) begin
              res_sts_d = STS_OVERFLOW;
              state_d   = ST_DONE;
            end else begin
              // hole at the new end, climb from there
              ent_d     = in_ent;
              idx_d     = count_ext;
              count_d   = count_q + CNT_W'(1);
              res_sts_d = STS_INSERTED;
              state_d   = ST_UP_RD;
            end
          end else begin
            if (count_q == '0) begin
              res_sts_d = STS_EMPTY;
              state_d   = ST_DONE;
            end else begin
              res_sts_d = STS_EXTRACT;
              state_d   = ST_EX_RD;
            end
          end
        end
      end

      ST_UP_RD: begin
        if (idx_q == '0) begin
          ram_we  = 1'b1;
          state_d = ST_DONE;
        end else begin
          ram_re  = 1'b1;
          state_d = ST_UP_CMP;
        end
      end

      ST_UP_CMP: begin
        // moving entry against its parent
        cmp_a  = ent_q.key;
        cmp_b  = rd_a.key;
        ram_we = 1'b1;
        if (cmp_lt) begin
          ram_wdata = rd_a;
          idx_d     = parent_idx;
          state_d   = ST_UP_RD;
        end else begin
          state_d   = ST_DONE;
        end
      end

      ST_EX_RD: begin
        // fetch root and last entry together
        ram_re      = 1'b1;
        ram_raddr_a = '0;
        ram_raddr_b = ADDR_W'(count_q - CNT_W'(1));
        state_d     = ST_EX_LOAD;
      end

      ST_EX_LOAD: begin
        res_tag_d = rd_a.tag;
        res_key_d = rd_a.key;
        ent_d     = rd_b;
        count_d   = count_q - CNT_W'(1);
        idx_d     = '0;
        state_d   = ST_DN_RD;
      end

      ST_DN_RD: begin
        if (left_idx >= count_ext) begin
          ram_we  = 1'b1;
          state_d = ST_DONE;
        end else begin
          ram_re      = 1'b1;
          ram_raddr_a = ADDR_W'(left_idx);
          state_d     = ST_DN_L;
        end
      end

      ST_DN_L: begin
        // left child against the moving entry
        cmp_a      = rd_a.key;
        cmp_b      = ent_q.key;
        left_sel_d = cmp_lt;
        best_d     = cmp_lt ? rd_a : ent_q;
        state_d    = ST_DN_R;
      end

      ST_DN_R: begin
        // right child against the better of the two; ties keep the left
        cmp_a  = rd_b.key;
        cmp_b  = best_q.key;
        ram_we = 1'b1;
        if (right_ok && cmp_lt) begin
          ram_wdata = rd_b;
          idx_d     = right_idx;
          state_d   = ST_DN_RD;
        end else if (left_sel_q) begin
          ram_wdata = best_q;
          idx_d     = left_idx;
          state_d   = ST_DN_RD;
        end else begin
          state_d   = ST_DONE;
        end
      end

      ST_DONE: begin
        // hold here while the previous result still waits
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {1'b0, count_q, res_key_q, res_tag_q};
          m_user_d  = res_sts_q;
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      cap_q     <= CNT_W'(CAP_MAX);
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    ent_q      <= ent_d;
    best_q     <= best_d;
    left_sel_q <= left_sel_d;
    res_tag_q  <= res_tag_d;
    res_key_q  <= res_key_d;
    res_sts_q  <= res_sts_d;
    m_data_q   <= m_data_d;
    m_user_q   <= m_user_d;
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
`ifndef SYNTH
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAP_MAX))
    else $error("fill count beyond heap size");

  a_count_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (count_q == $past(count_q) || count_q == $past(count_q) + CNT_W'(1) ||
              count_q == $past(count_q) - CNT_W'(1)))
    else $error("fill count moved by more than one");

  a_empty_extract : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_hs && s_axis_tuser[0] == ACT_EXTRACT && count_q == '0) |=>
      (state_q == ST_DONE && res_sts_q == STS_EMPTY && count_q == '0))
    else $error("extract on empty heap not reported");

  a_write_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q != ST_IDLE && state_q != ST_DONE))
    else $error("heap write outside a sift");
`endif

endmodule
`default_nettype wire
